### rtl/core/rfae_pkg.sv
// Shared types and constants of the register file ALU executor.
`default_nettype none
package rfae_pkg;

  localparam int NUM_REGS   = 26;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W  = 4;
  localparam int IDX_W = 5;
  localparam int IMM_W = 32;
  localparam int OUT_W = 32;

  localparam int AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [AW-1:0]         addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 4'd0,
    OP_OUT  = 4'd1,
    OP_MOVE = 4'd2,
    OP_EXCH = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_OPND,
    ST_PREP,
    ST_ITER,
    ST_FIX,
    ST_WR,
    ST_WR2,
    ST_RES
  } state_t;

endpackage
`default_nettype wire

### rtl/core/rfae_if.sv
// Command and result channel interfaces of the register file ALU executor.
`default_nettype none
interface rfae_cmd_if;
  import rfae_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        dest;
  logic [IDX_W-1:0]        src_a;
  logic [IDX_W-1:0]        src_b;
  logic                    three_operand;
  logic signed [IMM_W-1:0] immediate;

  modport source(output valid, op, dest, src_a, src_b, three_operand, immediate,
                 input ready);
  modport sink(input valid, op, dest, src_a, src_b, three_operand, immediate,
               output ready);
endinterface

interface rfae_res_if;
  import rfae_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic                    div_by_zero;

  modport source(output valid, value, div_by_zero, input ready);
  modport sink(input valid, value, div_by_zero, output ready);
endinterface
`default_nettype wire

### rtl/core/register_file_alu_executor.sv
// Top level: register file with a bit-serial ALU and radix-2 multiply/divide.
// Load writes the immediate directly; other commands read operands in ST_RD1 and
// ST_RD2, then out posts a result, move/exchange write back and ALU ops run the
// serial loop over DATA_WIDTH bits (div/mod by zero posts an error result). One
// command at a time; a pending result only holds back a next command that posts one.
// Reset: synchronous rst clears control state and all register valid bits,
// so every register reads as zero after reset. No clearing pass is needed.
`default_nettype none
module register_file_alu_executor (
  input  wire logic clk,
  input  wire logic rst,
  rfae_cmd_if.sink  cmd,
  rfae_res_if.source rsp
);
  import rfae_pkg::*;

  state_t state, state_next;

  op_t              op_q;
  logic [IDX_W-1:0] dest_q, a_q, b_q;
  logic             three_q;

  data_t              xs, ys, acc;
  logic               carry;
  logic               neg_q;
  logic [CNT_W-1:0]   cnt;

  data_t              mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  data_t              rdata;
  logic               rd_ok;
  data_t              rd_val;

  logic                    res_valid;
  logic signed [OUT_W-1:0] res_value;
  logic                    res_dbz;

  logic [IDX_W-1:0] r1, r2, rd_idx, wr_idx;
  addr_t            rd_addr, wr_addr;
  logic             rd_in, wr_in, mem_we;
  data_t            wr_data;
  logic             accept, post, slot_free;
  logic             is_divmod, bb, sbit, q_bit;
  logic [DATA_WIDTH:0] rem_sh, diff;
  data_t            fix_src;

  function automatic logic in_range(logic [IDX_W-1:0] idx);
    return 32'(idx) < NUM_REGS;
  endfunction

  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !res_valid || rsp.ready;
  assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);

  always_comb begin
    case (op_q)
      OP_MOVE: r1 = a_q;
      OP_OUT,
      OP_EXCH: r1 = dest_q;
      default: r1 = three_q ? a_q : dest_q;
    endcase
    case (op_q)
      OP_EXCH: r2 = a_q;
      default: r2 = three_q ? b_q : a_q;
    endcase
  end

  assign rd_idx  = (state == ST_RD1) ? r1 : r2;
  assign rd_addr = AW'(rd_idx);
  assign rd_in   = in_range(rd_idx);
  assign rd_val  = rd_ok ? rdata : '0;

  assign wr_idx  = (state == ST_WR2) ? a_q : dest_q;
  assign wr_addr = AW'(wr_idx);
  assign wr_in   = in_range(wr_idx);
  assign wr_data = (state == ST_WR2) ? xs : acc;

  // serial bit for add/sub/logic
  assign bb = ys[0] ^ (op_q == OP_SUB);
  always_comb begin
    case (op_q)
      OP_AND:  sbit = xs[0] & ys[0];
      OP_OR:   sbit = xs[0] | ys[0];
      OP_XOR:  sbit = xs[0] ^ ys[0];
      default: sbit = xs[0] ^ bb ^ carry;
    endcase
  end

  // restoring divide step: acc is the partial remainder, xs shifts the dividend out
  assign rem_sh  = {acc, xs[DATA_WIDTH-1]};
  assign diff    = rem_sh - {1'b0, ys};
  assign q_bit   = !diff[DATA_WIDTH];
  assign fix_src = (op_q == OP_MOD) ? acc : xs;

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    mem_we     = 1'b0;
    post       = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = (op_t'(cmd.op) == OP_LOAD) ? ST_WR : ST_RD1;
        end
      end
      ST_RD1: state_next = ST_RD2;
      ST_RD2: state_next = ST_OPND;
      ST_OPND: begin
        case (op_q)
          OP_OUT:  state_next = ST_RES;
          OP_MOVE,
          OP_EXCH: state_next = ST_WR;
          OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: state_next = ST_ITER;
          OP_DIV,
          OP_MOD:  state_next = (rd_val == '0) ? ST_RES : ST_PREP;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_PREP: state_next = ST_ITER;
      ST_ITER: begin
        if (cnt == '0) begin
          state_next = is_divmod ? ST_FIX : ST_WR;
        end
      end
      ST_FIX: state_next = ST_WR;
      ST_WR: begin
        mem_we     = wr_in;
        state_next = (op_q == OP_EXCH) ? ST_WR2 : ST_IDLE;
      end
      ST_WR2: begin
        mem_we     = wr_in;
        state_next = ST_IDLE;
      end
      ST_RES: begin
        if (slot_free) begin
          post       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == ST_RD1 || state == ST_RD2) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (state == ST_RD1 || state == ST_RD2) begin
        rd_ok <= rd_in && vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (post) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      res_dbz   <= (op_q != OP_OUT);
      res_value <= (op_q == OP_OUT) ? OUT_W'($signed(xs)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q    <= op_t'(cmd.op);
          dest_q  <= cmd.dest;
          a_q     <= cmd.src_a;
          b_q     <= cmd.src_b;
          three_q <= cmd.three_operand;
          acc     <= DATA_WIDTH'(cmd.immediate);
        end
      end
      ST_RD2: xs <= rd_val;
      ST_OPND: begin
        ys    <= rd_val;
        acc   <= (op_q == OP_EXCH) ? rd_val : (op_q == OP_MOVE) ? xs : '0;
        carry <= (op_q == OP_SUB);
        cnt   <= CNT_W'(DATA_WIDTH - 1);
      end
      ST_PREP: begin
        xs    <= xs[DATA_WIDTH-1] ? -xs : xs;
        ys    <= ys[DATA_WIDTH-1] ? -ys : ys;
        neg_q <= (op_q == OP_MOD) ? xs[DATA_WIDTH-1]
                                  : (xs[DATA_WIDTH-1] ^ ys[DATA_WIDTH-1]);
      end
      ST_ITER: begin
        cnt <= cnt - CNT_W'(1);
        case (op_q)
          OP_MUL: begin
            if (ys[0]) begin
              acc <= acc + xs;
            end
            xs <= {xs[DATA_WIDTH-2:0], 1'b0};
            ys <= {1'b0, ys[DATA_WIDTH-1:1]};
          end
          OP_DIV,
          OP_MOD: begin
            acc <= q_bit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            xs  <= {xs[DATA_WIDTH-2:0], q_bit};
          end
          default: begin
            acc   <= {sbit, acc[DATA_WIDTH-1:1]};
            carry <= (xs[0] & bb) | (xs[0] & carry) | (bb & carry);
            xs    <= {1'b0, xs[DATA_WIDTH-1:1]};
            ys    <= {1'b0, ys[DATA_WIDTH-1:1]};
          end
        endcase
      end
      ST_FIX: acc <= neg_q ? -fix_src : fix_src;
      default: ;
    endcase
  end

  assign rsp.valid       = res_valid;
  assign rsp.value       = res_value;
  assign rsp.div_by_zero = res_dbz;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("command beat did not start execution");

  a_iter_ends_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && state_next != ST_ITER) |-> cnt == '0)
    else $error("serial loop left early");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && is_divmod) |-> ys != '0)
    else $error("divide loop running with zero divisor");

  a_write_only_in_wb: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_WR || state == ST_WR2))
    else $error("register write outside write-back");

  a_dbz_value_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_dbz) |-> res_value == '0)
    else $error("error result carries nonzero value");
`endif

endmodule
`default_nettype wire
